/* src/cfce_pkg.sv */
// Shared constants and types for the CAN frame COBS encoder.
package cfce_pkg;

    localparam int BYTE_W                = 8;
    localparam int ID_W                  = 11;
    localparam int LEN_W                 = 4;
    localparam int PAYLOAD_W             = 64;
    localparam int MAX_PAYLOAD_BYTES_DEF = 8;
    localparam int HEADER_BYTES          = 2;
    localparam int CHECKSUM_BYTES        = 1;

    localparam logic [BYTE_W-1:0] FRAME_END_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] ID_LOW_MASK    = 8'hFF;
    localparam logic [2:0]        ID_HIGH_MASK   = 3'h7;

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

/* src/can_frame_cobs_encoder.sv */
// CAN frame COBS encoder: header, checksum, COBS stuffing and byte serializer.
//
//   channel | valid       | stall        | payload
//   --------+-------------+--------------+-----------------------------------
//   in      | i_in_valid  | o_in_stall   | i_can_id, i_data_len, i_payload
//   out     | o_out_valid | i_out_stall  | o_out_byte, o_last_byte
//
// A message is captured in the raw-frame register when it is accepted and is
// then COBS-encoded into the frame buffer, which sends one byte per cycle when not stalled.
// A message with length L (clamped) gives L+5 bytes, ending with the delimiter.
// The next message waits in the raw-frame register while a frame is sent and
// is loaded in the cycle the delimiter is taken, so frames follow gap-free.
// Reset (synchronous, active low) empties both stages. Output stalls hold the
// current byte and back up into o_in_stall once the raw-frame register is full.
module can_frame_cobs_encoder #(
    parameter int MAX_PAYLOAD_BYTES = cfce_pkg::MAX_PAYLOAD_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [cfce_pkg::ID_W-1:0]      i_can_id,
    input  logic [cfce_pkg::LEN_W-1:0]     i_data_len,
    input  logic [cfce_pkg::PAYLOAD_W-1:0] i_payload,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [cfce_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                           o_last_byte
);

    localparam int RAW_MAX = cfce_pkg::HEADER_BYTES + MAX_PAYLOAD_BYTES
                             + cfce_pkg::CHECKSUM_BYTES;
    localparam int STORE_DEPTH = RAW_MAX + 2;
    localparam int POS_W = $clog2(RAW_MAX + 1);
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int LEN_W = cfce_pkg::LEN_W;

    // raw frame build
    logic [LEN_W-1:0]     len_c;
    cfce_pkg::t_byte      pay_bytes [MAX_PAYLOAD_BYTES+1];
    cfce_pkg::t_byte      raw_in    [RAW_MAX];
    cfce_pkg::t_byte      sum;
    logic [POS_W-1:0]     n_in;

    always_comb begin
        len_c = (i_data_len > LEN_W'(MAX_PAYLOAD_BYTES)) ? LEN_W'(MAX_PAYLOAD_BYTES)
                                                         : i_data_len;
        for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
            pay_bytes[i] = i_payload[cfce_pkg::BYTE_W*i +: cfce_pkg::BYTE_W];
        end
        pay_bytes[MAX_PAYLOAD_BYTES] = '0;
        raw_in[0] = i_can_id[7:0] & cfce_pkg::ID_LOW_MASK;
        raw_in[1] = {len_c, 1'b0, i_can_id[10:8] & cfce_pkg::ID_HIGH_MASK};
        sum = raw_in[0] + raw_in[1];
        for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
            if (LEN_W'(i) < len_c) begin
                sum = sum + pay_bytes[i];
            end
        end
        for (int i = 0; i <= MAX_PAYLOAD_BYTES; i++) begin
            if (LEN_W'(i) < len_c) begin
                raw_in[i+2] = pay_bytes[i];
            end else if (LEN_W'(i) == len_c) begin
                raw_in[i+2] = cfce_pkg::t_byte'(8'd0 - sum);
            end else begin
                raw_in[i+2] = '0;
            end
        end
        n_in = POS_W'(len_c) + POS_W'(cfce_pkg::HEADER_BYTES + cfce_pkg::CHECKSUM_BYTES);
    end

    // control
    logic r_s1_valid;
    logic r_busy;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_last_idx;
    logic in_accept;
    logic out_take;
    logic out_done;
    logic load;

    assign out_take   = r_busy && !i_out_stall;
    assign out_done   = out_take && (r_idx == r_last_idx);
    assign load       = r_s1_valid && (!r_busy || out_done);
    assign o_in_stall = r_s1_valid && !load;
    assign in_accept  = i_in_valid && !o_in_stall;

    // raw frame register
    cfce_pkg::t_byte  r_raw [RAW_MAX];
    logic [POS_W-1:0] r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (load) begin
            r_s1_valid <= 1'b0;
        end
        if (in_accept) begin
            r_raw <= raw_in;
            r_n   <= n_in;
        end
    end

    // COBS encode
    logic             z   [RAW_MAX+1];
    logic [POS_W-1:0] nxt [RAW_MAX+1];
    logic [POS_W-1:0] first;
    cfce_pkg::t_byte  enc [STORE_DEPTH];

    always_comb begin
        for (int i = 0; i <= RAW_MAX; i++) begin
            if (i == RAW_MAX) begin
                z[i] = 1'b1;
            end else begin
                z[i] = (POS_W'(i) >= r_n) || (r_raw[i] == '0);
            end
        end
        nxt[RAW_MAX] = POS_W'(RAW_MAX);
        for (int i = RAW_MAX - 1; i >= 0; i--) begin
            nxt[i] = z[i+1] ? POS_W'(i + 1) : nxt[i+1];
        end
        first = z[0] ? '0 : nxt[0];
        enc[0] = cfce_pkg::t_byte'(first) + 8'd1;
        for (int i = 0; i < RAW_MAX; i++) begin
            if (POS_W'(i) < r_n) begin
                enc[i+1] = z[i] ? cfce_pkg::t_byte'(nxt[i] - POS_W'(i)) : r_raw[i];
            end else begin
                enc[i+1] = cfce_pkg::FRAME_END_BYTE;
            end
        end
        enc[RAW_MAX+1] = cfce_pkg::FRAME_END_BYTE;
    end

    // frame buffer and serializer
    cfce_pkg::t_byte r_frame [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (out_done) begin
            r_busy <= 1'b0;
        end else if (out_take) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (load) begin
            r_frame    <= enc;
            r_last_idx <= IDX_W'(r_n) + IDX_W'(1);
        end
    end

    assign o_out_valid = r_busy;
    assign o_out_byte  = r_frame[r_idx];
    assign o_last_byte = (r_idx == r_last_idx);

endmodule

/* test/can_frame_cobs_encoder_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the CAN message to COBS byte-frame encoder.
module can_frame_cobs_encoder_tb;

    localparam int ID_W        = cfce_pkg::ID_W;
    localparam int LEN_W       = cfce_pkg::LEN_W;
    localparam int PAYLOAD_W   = cfce_pkg::PAYLOAD_W;
    localparam int BYTE_W      = cfce_pkg::BYTE_W;
    localparam int MAX_BYTES   = cfce_pkg::MAX_PAYLOAD_BYTES_DEF;
    localparam int RAW_MAX     = cfce_pkg::HEADER_BYTES + MAX_BYTES
                                 + cfce_pkg::CHECKSUM_BYTES;
    localparam int ENC_MAX     = RAW_MAX + 2;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        cfce_pkg::t_byte value;
        logic            last;
    } t_enc_byte;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic [ID_W-1:0]      i_can_id    = '0;
    logic [LEN_W-1:0]     i_data_len  = '0;
    logic [PAYLOAD_W-1:0] i_payload   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_last_byte;

    t_enc_byte frame_bytes_due[$];
    int        mismatches   = 0;
    bit        tx_idle_on   = 1'b0;
    bit        rx_idle_on   = 1'b0;
    bit        hold_pending = 1'b0;

    can_frame_cobs_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_can_id   (i_can_id),
        .i_data_len (i_data_len),
        .i_payload  (i_payload),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_byte (o_out_byte),
        .o_last_byte(o_last_byte)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("can_frame_cobs_encoder_tb: errors");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void encode_frame(input logic [ID_W-1:0] id,
                                         input logic [LEN_W-1:0] len_in,
                                         input logic [PAYLOAD_W-1:0] data);
        cfce_pkg::t_byte raw [RAW_MAX];
        cfce_pkg::t_byte enc [ENC_MAX];
        cfce_pkg::t_byte sum;
        int              clen;
        int              code_at;
        int              pos;
        t_enc_byte       eb;
        clen = (len_in > MAX_BYTES) ? MAX_BYTES : int'(len_in);
        raw[0] = id[7:0];
        raw[1] = {clen[3:0], 1'b0, id[10:8]};
        for (int i = 0; i < clen; i++) begin
            raw[2 + i] = data[8*i +: 8];
        end
        sum = '0;
        for (int i = 0; i < clen + 2; i++) begin
            sum = sum + raw[i];
        end
        raw[clen + 2] = 8'd0 - sum;
        code_at = 0;
        pos = 1;
        for (int i = 0; i < clen + 3; i++) begin
            if (raw[i] == 8'h00) begin
                enc[code_at] = cfce_pkg::t_byte'(pos - code_at);
                code_at = pos;
            end else begin
                enc[pos] = raw[i];
            end
            pos++;
        end
        enc[code_at] = cfce_pkg::t_byte'(pos - code_at);
        enc[pos] = cfce_pkg::FRAME_END_BYTE;
        for (int i = 0; i <= pos; i++) begin
            eb.value = enc[i];
            eb.last  = (i == pos);
            frame_bytes_due.push_back(eb);
        end
    endfunction

    function automatic logic [PAYLOAD_W-1:0] sparse_payload();
        logic [PAYLOAD_W-1:0] data;
        data = {$urandom, $urandom};
        for (int i = 0; i < MAX_BYTES; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                data[8*i +: 8] = 8'h00;
            end
        end
        return data;
    endfunction

    task automatic send_msg(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                            input logic [PAYLOAD_W-1:0] data);
        if (tx_idle_on && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_can_id   <= id;
        i_data_len <= len;
        i_payload  <= data;
        do @(negedge i_clk); while (o_in_stall);
        encode_frame(id, len, data);
        @(posedge i_clk);
    endtask

    task automatic wait_drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (frame_bytes_due.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic test_field_extremes();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_msg(11'h000, 4'd0, 64'h0);
        send_msg(11'h7FF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        send_msg(11'h7FF, 4'd8, 64'h0102_0304_0506_0708);
        send_msg(11'h555, 4'd8, 64'h5555_5555_5555_5555);
        send_msg(11'h2AA, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA);
        send_msg(11'h100, 4'd1, 64'h0000_0000_0000_0080);
        wait_drain();
    endtask

    task automatic test_length_clamp();
        send_msg(11'h123, 4'd9,  64'h1122_3344_5566_7788);
        send_msg(11'h456, 4'd15, 64'h8877_6655_4433_2211);
        send_msg(11'h789, 4'd12, 64'h0);
        send_msg(11'h0F0, 4'd2,  64'hDEAD_BEEF_CAFE_5AA5);
        send_msg(11'h00F, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF);
        wait_drain();
    endtask

    task automatic test_zero_stuffing();
        send_msg(11'h000, 4'd1, 64'h0000_0000_0000_00F0);
        send_msg(11'h400, 4'd4, 64'h0000_0000_0000_0000);
        send_msg(11'h001, 4'd8, 64'h0011_0000_2200_0033);
        send_msg(11'h300, 4'd3, 64'h0000_0000_0000_1200);
        send_msg(11'h0FF, 4'd8, 64'h0000_0000_0000_0000);
        wait_drain();
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int i = 0; i < 6; i++) begin
            send_msg(ID_W'($urandom), LEN_W'($urandom_range(0, 8)), sparse_payload());
        end
        wait_drain();
    endtask

    task automatic test_output_backpressure();
        hold_pending = 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < 10; i++) begin
            send_msg(ID_W'($urandom), LEN_W'($urandom_range(0, 8)), sparse_payload());
        end
        wait_drain();
    endtask

    task automatic test_random_traffic(input int count, input bit with_idle);
        logic [LEN_W-1:0] len;
        tx_idle_on = with_idle;
        rx_idle_on = with_idle;
        for (int i = 0; i < count; i++) begin
            len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15))
                                               : LEN_W'($urandom_range(0, 8));
            send_msg(ID_W'($urandom), len, sparse_payload());
        end
        wait_drain();
    endtask

    // receiver: random stall bursts, plus one long hold on request
    initial begin : rx_stall_gen
        int hold_left;
        int burst_left;
        hold_left  = 0;
        burst_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_out_stall <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(1, 8) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : frame_checker
        t_enc_byte eb;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (frame_bytes_due.size() == 0) begin
                    report_mismatch("unexpected byte", int'(o_out_byte), 0);
                end else begin
                    eb = frame_bytes_due.pop_front();
                    if (o_out_byte !== eb.value)
                        report_mismatch("out_byte", int'(o_out_byte), int'(eb.value));
                    if (o_last_byte !== eb.last)
                        report_mismatch("last_byte", int'(o_last_byte), int'(eb.last));
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_field_extremes();
        test_length_clamp();
        test_zero_stuffing();
        test_back_to_back();
        test_output_backpressure();
        test_random_traffic(110, 1'b1);
        test_random_traffic(40, 1'b0);
        wait_drain();
        if (frame_bytes_due.size() != 0)
            report_mismatch("frame bytes never emitted", frame_bytes_due.size(), 0);
        if (mismatches == 0) begin
            $display("can_frame_cobs_encoder_tb: clean");
        end else begin
            $display("can_frame_cobs_encoder_tb: errors");
        end
        $finish;
    end

endmodule
